// ----- rtl/assert_macros.svh -----
// Concurrent assertion helpers, disabled for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop at every rising edge outside reset.
`define TVA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define TVA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define TVA_ASSERT(label, clk, rst_n, prop, msg)
`define TVA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/tva_pkg.sv -----
`default_nettype none

package tva_pkg;

  localparam int COORD_BITS = 16;
  localparam int VTX_W      = 16;
  localparam int COEF_W     = 16;
  localparam int ROW_W      = 64;
  localparam int Q_W        = 32;
  localparam int NUM_AXES   = 3;
  localparam int TRANS_SHIFT = 8;

  localparam int PROD_W = COEF_W + COORD_BITS;
  localparam int SUM_W  = (PROD_W + 2 > Q_W + 1) ? PROD_W + 2 : Q_W + 1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Z = 2'd2;

  localparam logic [ROW_W-1:0] ROW_X_RESET = 64'h0000_0000_0000_0100;
  localparam logic [ROW_W-1:0] ROW_Y_RESET = 64'h0000_0000_0100_0000;
  localparam logic [ROW_W-1:0] ROW_Z_RESET = 64'h0000_0100_0000_0000;

  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef logic [NUM_AXES-1:0][ROW_W-1:0] row_set_t;

  typedef struct packed {
    logic signed [Q_W-1:0] px;
    logic signed [Q_W-1:0] py;
    logic signed [Q_W-1:0] pz;
    logic                  last;
  } point_t;

  function automatic logic signed [COEF_W-1:0] coef_of(input logic [ROW_W-1:0] row,
                                                       input int k);
    logic signed [COEF_W-1:0] c;
    c = row[COEF_W*k +: COEF_W];
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tva_vertex_if.sv -----
`default_nettype none

interface tva_vertex_if;
  import tva_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VTX_W-1:0] vertex_x;
  logic signed [VTX_W-1:0] vertex_y;
  logic signed [VTX_W-1:0] vertex_z;
  logic                    last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                  output last_vertex, input ready);
  modport sink (input valid, input vertex_x, input vertex_y, input vertex_z,
                input last_vertex, output ready);
endinterface

`default_nettype wire

// ----- rtl/tva_box_if.sv -----
`default_nettype none

interface tva_box_if;
  import tva_pkg::*;

  logic                  valid;
  logic                  ready;
  logic signed [Q_W-1:0] center_x;
  logic signed [Q_W-1:0] center_y;
  logic signed [Q_W-1:0] center_z;
  logic [Q_W-1:0]        extent_x;
  logic [Q_W-1:0]        extent_y;
  logic [Q_W-1:0]        extent_z;

  modport source (output valid, output center_x, output center_y, output center_z,
                  output extent_x, output extent_y, output extent_z, input ready);
  modport sink (input valid, input center_x, input center_y, input center_z,
                input extent_x, input extent_y, input extent_z, output ready);
endinterface

`default_nettype wire

// ----- rtl/tva_cfg_if.sv -----
`default_nettype none

interface tva_cfg_if;
  import tva_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [ROW_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/tva_cfg_regs.sv -----
`default_nettype none

module tva_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  tva_cfg_if.sink           cfg_ch,
  output tva_pkg::row_set_t rows
);
  import tva_pkg::*;

  logic [ROW_W-1:0] row_x_r, row_y_r, row_z_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_x_r <= ROW_X_RESET;
      row_y_r <= ROW_Y_RESET;
      row_z_r <= ROW_Z_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_ROW_X: row_x_r <= cfg_ch.data;
        REG_ROW_Y: row_y_r <= cfg_ch.data;
        REG_ROW_Z: row_z_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign rows[0] = row_x_r;
  assign rows[1] = row_y_r;
  assign rows[2] = row_z_r;

endmodule

`default_nettype wire

// ----- rtl/tva_xform.sv -----
`default_nettype none

module tva_xform (
  input  logic              clk,
  input  logic              rst_n,
  tva_vertex_if.sink        in_ch,
  input  tva_pkg::row_set_t rows,
  output logic              pt_valid,
  output tva_pkg::point_t   pt,
  input  logic              pt_ready
);
  import tva_pkg::*;

  logic                         v0_r, v1_r, v2_r;
  logic                         rdy0, rdy1, rdy2;
  logic signed [COORD_BITS-1:0] crd0_r [NUM_AXES];
  logic                         last0_r, last1_r;
  logic signed [PROD_W-1:0]     prod_r [NUM_AXES][NUM_AXES];
  logic signed [PROD_W-1:0]     prod_nxt [NUM_AXES][NUM_AXES];
  logic signed [COEF_W-1:0]     trans_r [NUM_AXES];
  logic signed [COEF_W-1:0]     trans_nxt [NUM_AXES];
  logic signed [Q_W-1:0]        p_nxt [NUM_AXES];
  point_t                       pt_r;

  assign rdy2 = !v2_r || pt_ready;
  assign rdy1 = !v1_r || rdy2;
  assign rdy0 = !v0_r || rdy1;
  assign in_ch.ready = rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_ch.valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
    end
  end

  // Stage 0: capture the vertex
  always_ff @(posedge clk) begin
    if (rdy0 && in_ch.valid) begin
      crd0_r[0] <= COORD_BITS'(in_ch.vertex_x);
      crd0_r[1] <= COORD_BITS'(in_ch.vertex_y);
      crd0_r[2] <= COORD_BITS'(in_ch.vertex_z);
      last0_r   <= in_ch.last_vertex;
    end
  end

  // Stage 1: products
  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        prod_nxt[r][c] = PROD_W'(coef_of(rows[r], c)) * PROD_W'(crd0_r[c]);
      end
      trans_nxt[r] = coef_of(rows[r], NUM_AXES);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && v0_r) begin
      prod_r  <= prod_nxt;
      trans_r <= trans_nxt;
      last1_r <= last0_r;
    end
  end

  // Stage 2: sum and saturate
  always_comb begin
    logic signed [SUM_W-1:0] s;
    for (int r = 0; r < NUM_AXES; r++) begin
      s = SUM_W'(prod_r[r][0]) + SUM_W'(prod_r[r][1]) + SUM_W'(prod_r[r][2])
        + (SUM_W'(trans_r[r]) <<< TRANS_SHIFT);
      priority if (s > SUM_W'(Q_MAX)) begin
        p_nxt[r] = Q_MAX;
      end else if (s < SUM_W'(Q_MIN)) begin
        p_nxt[r] = Q_MIN;
      end else begin
        p_nxt[r] = Q_W'(s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      pt_r.px   <= p_nxt[0];
      pt_r.py   <= p_nxt[1];
      pt_r.pz   <= p_nxt[2];
      pt_r.last <= last1_r;
    end
  end

  assign pt_valid = v2_r;
  assign pt       = pt_r;

endmodule

`default_nettype wire

// ----- rtl/tva_box.sv -----
`default_nettype none

module tva_box (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pt_valid,
  input  tva_pkg::point_t pt,
  output logic            pt_ready,
  tva_box_if.source       out_ch
);
  import tva_pkg::*;

  logic signed [Q_W-1:0] lo_r [NUM_AXES];
  logic signed [Q_W-1:0] hi_r [NUM_AXES];
  logic signed [Q_W-1:0] lo_nxt [NUM_AXES];
  logic signed [Q_W-1:0] hi_nxt [NUM_AXES];
  logic signed [Q_W-1:0] p [NUM_AXES];
  logic signed [Q_W-1:0] center_nxt [NUM_AXES];
  logic [Q_W-1:0]        extent_nxt [NUM_AXES];
  logic signed [Q_W-1:0] center_r [NUM_AXES];
  logic [Q_W-1:0]        extent_r [NUM_AXES];
  logic                  out_valid_r;
  logic                  out_free;
  logic                  go;

  assign out_free = !out_valid_r || out_ch.ready;
  assign pt_ready = !pt.last || out_free;
  assign go       = pt_valid && pt_ready;

  assign p[0] = pt.px;
  assign p[1] = pt.py;
  assign p[2] = pt.pz;

  always_comb begin
    logic signed [Q_W:0] s;
    for (int a = 0; a < NUM_AXES; a++) begin
      lo_nxt[a]     = (p[a] < lo_r[a]) ? p[a] : lo_r[a];
      hi_nxt[a]     = (p[a] > hi_r[a]) ? p[a] : hi_r[a];
      s             = (Q_W + 1)'(hi_nxt[a]) + (Q_W + 1)'(lo_nxt[a]);
      center_nxt[a] = s[Q_W:1];
      extent_nxt[a] = Q_W'(hi_nxt[a] - lo_nxt[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
        lo_r[a] <= Q_MAX;
        hi_r[a] <= Q_MIN;
      end
    end else begin
      if (go && pt.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (go) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          lo_r[a] <= pt.last ? Q_MAX : lo_nxt[a];
          hi_r[a] <= pt.last ? Q_MIN : hi_nxt[a];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && pt.last) begin
      center_r <= center_nxt;
      extent_r <= extent_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.center_x = center_r[0];
  assign out_ch.center_y = center_r[1];
  assign out_ch.center_z = center_r[2];
  assign out_ch.extent_x = extent_r[0];
  assign out_ch.extent_y = extent_r[1];
  assign out_ch.extent_z = extent_r[2];

endmodule

`default_nettype wire

// ----- rtl/transformed_vertex_aabb.sv -----
// A box follows an object's last vertex through capture, product, sum and output registers.
// Throughput: one vertex per cycle. While a box result waits in the output register, inner
// vertices still advance; the next last vertex holds in the sum register, and the input
// stalls once the input and product registers behind it are full.
// Reset (rst_n low, synchronous): empties the pipeline and output register, returns the
// min/max state to its extremes and the three transform rows to identity.
`default_nettype none
`include "assert_macros.svh"

module transformed_vertex_aabb (
  input  logic       clk,
  input  logic       rst_n,
  tva_vertex_if.sink in_ch,
  tva_box_if.source  out_ch,
  tva_cfg_if.sink    cfg_ch
);
  import tva_pkg::*;

  row_set_t rows;
  logic     pt_valid;
  logic     pt_ready;
  point_t   pt;

  tva_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .rows   (rows)
  );

  tva_xform u_xform (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .rows     (rows),
    .pt_valid (pt_valid),
    .pt       (pt),
    .pt_ready (pt_ready)
  );

  tva_box u_box (
    .clk      (clk),
    .rst_n    (rst_n),
    .pt_valid (pt_valid),
    .pt       (pt),
    .pt_ready (pt_ready),
    .out_ch   (out_ch)
  );

  `TVA_ASSERT_NEXT(a_last_gives_result, clk, rst_n, pt_valid && pt_ready && pt.last,
                   out_ch.valid, "last vertex produced no result")
  `TVA_ASSERT_NEXT(a_inner_no_result, clk, rst_n, pt_valid && pt_ready && !pt.last,
                   out_ch.valid == $past(out_ch.valid && !out_ch.ready),
                   "result appeared on an inner vertex")
  `TVA_ASSERT(a_stall_from_output, clk, rst_n,
              !in_ch.ready |-> (out_ch.valid && !out_ch.ready),
              "input stalled without a held result")

endmodule

`default_nettype wire
